### sv/utf8_stream_decoder_assert.svh
// Assertion macros for the UTF-8 stream decoder.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define U8D_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8 decoder: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define U8D_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8 decoder: next-cycle check failed");

`endif

### sv/u8d_pkg.sv
// Shared types, constants and helper functions of the UTF-8 stream decoder.
// No dependencies; the controller, the datapath and the top level import this package.
package u8d_pkg;

  // Sequence length codes returned by seq_len().
  localparam logic [2:0] SEQ_INVALID = 3'd0;
  localparam logic [2:0] SEQ_ONE     = 3'd1;
  localparam logic [2:0] SEQ_TWO     = 3'd2;
  localparam logic [2:0] SEQ_THREE   = 3'd3;
  localparam logic [2:0] SEQ_FOUR    = 3'd4;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } text_beat_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        bad_sequence;
    logic [2:0]  bytes_used;
    logic        run_last;
    logic        text_done;
  } point_beat_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } u8d_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // append the incoming byte to the buffer
    logic consume;  // emit the decoded front sequence and drop its bytes
  } u8d_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stop;      // nothing to emit until more bytes arrive
    logic last;      // the result decoded now is the last one of this byte
    logic out_free;  // the output register can take a beat this cycle
  } u8d_status_t;

  // Total sequence length implied by a lead byte.
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] n;
    priority if (b[7] == 1'b0) begin
      n = SEQ_ONE;
    end else if (b[7:5] == 3'b110) begin
      n = SEQ_TWO;
    end else if (b[7:4] == 4'b1110) begin
      n = SEQ_THREE;
    end else if (b[7:3] == 5'b11110) begin
      n = SEQ_FOUR;
    end else begin
      n = SEQ_INVALID;
    end
    return n;
  endfunction

endpackage

### sv/u8d_chan_if.sv
// Valid/ready channel interface with a typed payload.
// Payload types come from u8d_pkg at the place of instantiation.
interface u8d_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### sv/u8d_ctrl.sv
// Controller state machine of the UTF-8 stream decoder.
// Depends on u8d_pkg for the state, command and status types.
module u8d_ctrl
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  input  u8d_status_t status,
  output logic        text_ready,
  output u8d_cmd_t    cmd
);

  u8d_state_t state;
  u8d_state_t state_next;
  logic       emit_ok;
  logic       finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A scan cycle finishes the current byte when nothing can be emitted
  // or when the beat going out is the last one for this byte.
  assign emit_ok = !status.stop && status.out_free;
  assign finish  = status.stop || (emit_ok && status.last);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (text_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (finish && !text_valid) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    text_ready  = 1'b0;
    cmd.load    = 1'b0;
    cmd.consume = 1'b0;
    unique case (state)
      ST_IDLE: begin
        text_ready = 1'b1;
        cmd.load   = text_valid;
      end
      ST_SCAN: begin
        text_ready  = finish;
        cmd.load    = finish && text_valid;
        cmd.consume = emit_ok;
      end
      default: begin
        text_ready = 1'b0;
      end
    endcase
  end

endmodule

### sv/u8d_datapath.sv
// Datapath of the UTF-8 stream decoder: byte buffer, sequence decoder and
// output register. Depends on u8d_pkg and u8d_chan_if.
module u8d_datapath
  import u8d_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    text_byte,
  input  logic          final_byte,
  input  u8d_cmd_t      cmd,
  output u8d_status_t   status,
  u8d_chan_if.source    points
);

  logic [7:0]  buffer [4];
  logic [7:0]  buffer_next [4];
  logic [7:0]  buffer_shift [4];
  logic [2:0]  cnt;
  logic [2:0]  cnt_next;
  logic        fin;
  logic        out_valid;
  point_beat_t out_beat;

  logic [2:0]  need;
  logic        short_seq;
  logic [10:0] v2;
  logic [15:0] v3;
  logic [20:0] v4;
  logic        c1, c2, c3;
  logic        ok2, ok3, ok4;
  logic        bad;
  logic [2:0]  used;
  logic [20:0] cp;
  logic [2:0]  cnt_rem;
  logic [2:0]  cnt_after;
  logic [2:0]  next_need;
  logic [2:0]  src;

  // Candidate values for each sequence length, straight from the bit fields.
  assign v2 = {buffer[0][4:0], buffer[1][5:0]};
  assign v3 = {buffer[0][3:0], buffer[1][5:0], buffer[2][5:0]};
  assign v4 = {buffer[0][2:0], buffer[1][5:0], buffer[2][5:0], buffer[3][5:0]};
  assign c1 = (buffer[1][7:6] == 2'b10);
  assign c2 = (buffer[2][7:6] == 2'b10);
  assign c3 = (buffer[3][7:6] == 2'b10);

  assign ok2 = c1 && (v2 >= 11'h080);
  assign ok3 = c1 && c2 && (v3 >= 16'h0800) && !((v3 >= 16'hD800) && (v3 <= 16'hDFFF));
  assign ok4 = c1 && c2 && c3 && (v4 >= 21'h010000) && (v4 <= 21'h10FFFF);

  assign need      = seq_len(buffer[0]);
  assign short_seq = (need >= SEQ_TWO) && (cnt < need);

  always_comb begin
    bad  = 1'b0;
    used = SEQ_ONE;
    cp   = REPLACEMENT_CP;
    unique case (need)
      SEQ_ONE: begin
        cp = {13'd0, buffer[0]};
      end
      SEQ_TWO: begin
        bad = short_seq || !ok2;
        cp  = {10'd0, v2};
      end
      SEQ_THREE: begin
        bad = short_seq || !ok3;
        cp  = {5'd0, v3};
      end
      SEQ_FOUR: begin
        bad = short_seq || !ok4;
        cp  = v4;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    if (bad) begin
      cp = REPLACEMENT_CP;
    end else begin
      used = need;
    end
  end

  // Remaining bytes after this result and whether another result follows.
  assign cnt_rem   = cnt - used;
  assign next_need = seq_len(buffer[used[1:0]]);

  assign status.stop     = (cnt == 3'd0) || (short_seq && !fin);
  assign status.last     = (cnt_rem == 3'd0) ||
                           (!fin && (next_need >= SEQ_TWO) && (cnt_rem < next_need));
  assign status.out_free = !out_valid || points.ready;

  always_comb begin
    src = 3'd0;
    for (int i = 0; i < 4; i++) begin
      src = 3'(i) + used;
      buffer_shift[i] = (src < 3'd4) ? buffer[src[1:0]] : 8'd0;
    end
    cnt_after = cmd.consume ? cnt_rem : cnt;
    for (int i = 0; i < 4; i++) begin
      buffer_next[i] = cmd.consume ? buffer_shift[i] : buffer[i];
    end
    if (cmd.load) begin
      buffer_next[cnt_after[1:0]] = text_byte;
    end
    cnt_next = cnt_after + {2'd0, cmd.load};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= 3'd0;
      fin       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (cmd.load) fin <= final_byte;
      if (cmd.consume) begin
        out_valid <= 1'b1;
      end else if (points.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      buffer[i] <= buffer_next[i];
    end
    if (cmd.consume) begin
      out_beat.code_point   <= cp;
      out_beat.bad_sequence <= bad;
      out_beat.bytes_used   <= used;
      out_beat.run_last     <= status.last;
      out_beat.text_done    <= status.last && fin;
    end
  end

  assign points.valid   = out_valid;
  assign points.payload = out_beat;

endmodule

### sv/utf8_stream_decoder.sv
// UTF-8 stream decoder, top level: controller plus datapath, valid/ready beats.
// A byte is first registered in the byte buffer, and its result then in the output register.
// Throughput: one byte per cycle while each byte yields at most one result and the output
// is not stalled; a byte with several results holds the input, one decoder scan step each.
// Reset (rst, synchronous, active high) empties the byte buffer and the output register.
// Depends on u8d_pkg, u8d_chan_if, u8d_ctrl, u8d_datapath and the assertion header.
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  u8d_chan_if.sink   text,
  u8d_chan_if.source points
);

  // The controller and the datapath talk only through these two structs.
  u8d_cmd_t    cmd;
  u8d_status_t status;
  logic        text_ready;

  // The controller owns the input handshake. It takes a byte whenever it is
  // idle; otherwise in the same cycle in which the previous byte's last result
  // goes out, or when the buffer must wait for more bytes to complete a sequence.
  u8d_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text.valid),
    .status     (status),
    .text_ready (text_ready),
    .cmd        (cmd)
  );

  assign text.ready = text_ready;

  // The datapath holds up to four bytes, decodes the sequence at the front
  // each cycle, and drives the output register. A rejected sequence drops
  // only its lead byte, so the remaining bytes are scanned again on the
  // next cycle.
  u8d_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .text_byte  (text.payload.text_byte),
    .final_byte (text.payload.final_byte),
    .cmd        (cmd),
    .status     (status),
    .points     (points)
  );

  // A final byte always leaves something to emit on the following cycle.
  `U8D_ASSERT_NXT(a_final_emits, text.valid && text.ready && text.payload.final_byte, !status.stop)
  // A beat waiting on a stalled output is never overwritten.
  `U8D_ASSERT_IMP(a_no_overwrite, points.valid && !points.ready, !cmd.consume)
  // Every emit command shows up as a valid output beat.
  `U8D_ASSERT_NXT(a_emit_visible, cmd.consume, points.valid)

endmodule
